### rtl/gsu_pkg.sv
// shared types, constants and septet mapping for the septet unpacker
// no dependencies
`default_nettype none

package gsu_pkg;

	localparam int unsigned SEPT_W  = 7;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CNT_W   = 8;
	localparam int unsigned BUF_W   = 6;
	localparam int unsigned HELD_W  = 3;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_DATA  = 1'b1;

	localparam logic [SEPT_W-1:0] SEPT_AT     = 7'h00;
	localparam logic [SEPT_W-1:0] SEPT_DOLLAR = 7'h02;
	localparam logic [SEPT_W-1:0] CHAR_AT     = 7'h40;
	localparam logic [SEPT_W-1:0] CHAR_DOLLAR = 7'h24;

	// bits held when a byte completes two septets
	localparam logic [HELD_W-1:0] HELD_FULL = 3'd6;

	typedef struct packed {
		logic [SEPT_W-1:0] character;
		logic              last;
	} sept_t;

	// one to two results caused by one data byte
	typedef struct packed {
		sept_t c0;
		sept_t c1;
		logic  has_c1;
	} group_t;

	function automatic logic [SEPT_W-1:0] map_septet(input logic [SEPT_W-1:0] s);
		logic [SEPT_W-1:0] r;
		begin
			r = s;
			if (s == SEPT_AT) begin
				r = CHAR_AT;
			end else if (s == SEPT_DOLLAR) begin
				r = CHAR_DOLLAR;
			end
			return r;
		end
	endfunction

endpackage

`default_nettype wire

### rtl/gsu_front.sv
// front end: accepts items, keeps the bit buffer and counters, forms result groups
// depends on gsu_pkg
`default_nettype none

module gsu_front import gsu_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic              kind,
	input  wire logic [BYTE_W-1:0] data_byte,
	input  wire logic [CNT_W-1:0]  septet_count,
	input  wire logic [CNT_W-1:0]  skip_count,
	output logic                   push,
	output group_t                 grp
);

	logic [BUF_W-1:0]  buf_q;
	logic [HELD_W-1:0] held_q;
	logic [CNT_W-1:0]  sl_q;
	logic [CNT_W-1:0]  sk_q;

	logic [13:0]       merged;
	logic [SEPT_W-1:0] s0, s1;
	logic [CNT_W-1:0]  sl1, sl2, sk1, sk2;
	logic              open, take1, e0, e1;
	logic [CNT_W-1:0]  sl_n, sk_n;
	logic [BUF_W-1:0]  buf_n;
	logic [HELD_W-1:0] held_n;

	always_comb begin
		merged = {8'b0, buf_q} | ({6'b0, data_byte} << held_q);
		s0     = merged[6:0];
		s1     = merged[13:7];
		open   = (sl_q != '0);
		sl1    = sl_q - 8'd1;
		sk1    = (sk_q != '0) ? sk_q - 8'd1 : sk_q;
		e0     = (sk_q == '0);
		take1  = (held_q == HELD_FULL) && (sl1 != '0);
		sl2    = take1 ? sl1 - 8'd1 : sl1;
		e1     = take1 && (sk1 == '0);
		sk2    = (take1 && sk1 != '0) ? sk1 - 8'd1 : sk1;
		sl_n   = sl2;
		sk_n   = sk2;
		if (take1 || sl2 == '0) begin
			buf_n  = '0;
			held_n = '0;
		end else begin
			buf_n  = merged[12:7];
			held_n = held_q + 3'd1;
		end
		grp.c0.character = e0 ? map_septet(s0) : map_septet(s1);
		grp.c0.last      = e0 ? (sl1 == '0) : (sl2 == '0);
		grp.c1.character = map_septet(s1);
		grp.c1.last      = (sl2 == '0);
		grp.has_c1       = e0 && e1;
		push = accept && (kind == KIND_DATA) && open && (e0 || e1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q  <= '0;
			held_q <= '0;
			sl_q   <= '0;
			sk_q   <= '0;
		end else if (accept) begin
			if (kind == KIND_START) begin
				buf_q  <= '0;
				held_q <= '0;
				sl_q   <= septet_count;
				sk_q   <= skip_count;
			end else if (open) begin
				buf_q  <= buf_n;
				held_q <= held_n;
				sl_q   <= sl_n;
				sk_q   <= sk_n;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/gsu_queue.sv
// short queue of result groups between front and back
// depends on gsu_pkg
`default_nettype none

module gsu_queue import gsu_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  group_t    wdata,
	input  wire logic pop,
	output group_t    rdata,
	output logic      full,
	output logic      empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	group_t        mem [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/gsu_back.sv
// back end: splits result groups into single results behind an output register
// depends on gsu_pkg
`default_nettype none

module gsu_back import gsu_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  group_t                 grp,
	input  wire logic              grp_avail,
	output logic                   grp_pop,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output logic [SEPT_W-1:0]      character,
	output logic                   last
);

	logic  out_valid_q;
	sept_t out_q;
	logic  pend_valid_q;
	sept_t pend_q;
	logic  adv;

	assign adv          = !out_valid_q || result_ready;
	assign grp_pop      = adv && !pend_valid_q && grp_avail;
	assign result_valid = out_valid_q;
	assign character    = out_q.character;
	assign last         = out_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (adv) begin
			if (pend_valid_q) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (grp_avail) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= grp.has_c1;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (pend_valid_q) begin
				out_q <= pend_q;
			end else if (grp_avail) begin
				out_q  <= grp.c0;
				pend_q <= grp.c1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/gsu_top.sv
// top level of the gsm septet unpacker: front end, group queue, back end
// depends on gsu_pkg, gsu_front, gsu_queue, gsu_back
`default_nettype none

// gsm 7-bit septet unpacker. a start transaction (kind 0) loads the septet
// count and the header skip count and clears the bit buffer; data
// transactions (kind 1) carry one packed byte each, unpacked lsb first into
// septets. header septets are swallowed, septet 0 comes out as '@' and
// septet 2 as '$', and the final counted septet carries last. bytes after
// the message end are dropped until the next start. the front end takes one
// transaction per clock as long as the group queue has room; each data byte
// that yields characters becomes one group of up to two. the back end emits
// one character per clock through a registered output while result_ready
// is high, so bytes giving one character pass at one byte per clock; the
// byte in seven that gives two holds the back end for both. a byte's first
// character goes through the queue memory and the output register. the
// QUEUE_DEPTH sets how many groups can wait while the output is stalled.
module gsm_septet_unpacker_top import gsu_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// item channel
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire logic              kind,
	input  wire logic [BYTE_W-1:0] data_byte,
	input  wire logic [CNT_W-1:0]  septet_count,
	input  wire logic [CNT_W-1:0]  skip_count,
	// result channel
	output logic                   result_valid,
	input  wire logic              result_ready,
	output logic [SEPT_W-1:0]      character,
	output logic                   last
);

	logic   accept;
	logic   push;
	group_t grp_in;
	group_t grp_out;
	logic   q_full, q_empty, q_pop;

	// front only stalls when the queue has no room for a group
	assign item_ready = !q_full;
	assign accept     = item_valid && item_ready;

	gsu_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.kind         (kind),
		.data_byte    (data_byte),
		.septet_count (septet_count),
		.skip_count   (skip_count),
		.push         (push),
		.grp          (grp_in)
	);

	gsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (grp_in),
		.pop    (q_pop),
		.rdata  (grp_out),
		.full   (q_full),
		.empty  (q_empty)
	);

	// back drains groups one character at a time
	gsu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.grp          (grp_out),
		.grp_avail    (!q_empty),
		.grp_pop      (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.character    (character),
		.last         (last)
	);

endmodule

`default_nettype wire
